// ===== sv/c80_pkg.sv =====
// Package for the 8080 register and ALU execute block.
// Holds operation codes, variant codes and the item structs; no dependencies.
`default_nettype none
package c80_pkg;
    localparam int unsigned QueueDepth = 2;

    localparam logic [4:0] OP_NOP = 5'd0, OP_MOV = 5'd1, OP_MVI = 5'd2, OP_LXI = 5'd3,
        OP_ALU = 5'd4, OP_INR = 5'd5, OP_DCR = 5'd6, OP_INX = 5'd7, OP_DCX = 5'd8,
        OP_DAD = 5'd9, OP_ROT = 5'd10, OP_CMA = 5'd11, OP_STC = 5'd12, OP_CMC = 5'd13,
        OP_XCHG = 5'd14, OP_SPHL = 5'd15, OP_JMP = 5'd16, OP_PCHL = 5'd17;

    localparam logic [3:0] ALU_ADD = 4'd0, ALU_ADC = 4'd1, ALU_SUB = 4'd2,
        ALU_SBB = 4'd3, ALU_ANA = 4'd4, ALU_XRA = 4'd5, ALU_ORA = 4'd6, ALU_CMP = 4'd7;

    localparam logic [3:0] ROT_RLC = 4'd0, ROT_RRC = 4'd1, ROT_RAL = 4'd2, ROT_RAR = 4'd3;

    localparam logic [2:0] REG_A = 3'd6, REG_MEM = 3'd7;

    typedef struct packed {
        logic [4:0]  operation;
        logic [3:0]  variant;
        logic [2:0]  dest_reg;
        logic [2:0]  src_reg;
        logic [1:0]  pair_sel;
        logic        use_immediate;
        logic [15:0] immediate;
    } instr_t;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  psw_flags;
        logic        jump_taken;
        logic [15:0] new_pc;
        logic [15:0] pair_bc;
        logic [15:0] pair_de;
        logic [15:0] pair_hl;
        logic [15:0] stack_ptr;
    } result_t;
endpackage
`default_nettype wire

// ===== sv/c80_instr_if.sv =====
// Valid/ready channel interfaces for instructions and results.
// Depends on c80_pkg for the payload structs.
`default_nettype none
interface c80_instr_if import c80_pkg::*;;
    logic   valid;
    logic   ready;
    instr_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface c80_result_if import c80_pkg::*;;
    logic    valid;
    logic    ready;
    result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/cpu8080_register_alu_execute.sv =====
// Top level of the 8080 register and ALU execute block.
// Depends on c80_pkg, the channel interfaces, c80_front, c80_queue and c80_exec.
//   channel | role   | payload
//   in      | sink   | instr_t: one decoded instruction
//   out     | source | result_t: registers and flags after it
// One instruction per cycle while the output is not stalled; each passes through the
// queue and then the execute stage, whose register file update sets the rate.
// Reset clears the registers, flags, stack pointer and the queue.
// A stalled output holds in its register; the queue absorbs two further transfers.
`default_nettype none
module cpu8080_register_alu_execute import c80_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input wire logic clk,
    input wire logic rst_n,
    c80_instr_if.sink in,
    c80_result_if.source out
);
    logic   push, full, pop, empty;
    instr_t push_data, pop_data;

    c80_front u_front (.in(in), .full(full), .push(push), .push_data(push_data));

    c80_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(full),
        .pop(pop), .pop_data(pop_data), .empty(empty)
    );

    c80_exec u_exec (
        .clk(clk), .rst_n(rst_n), .empty(empty), .ins(pop_data), .pop(pop), .out(out)
    );
endmodule
`default_nettype wire

// ===== sv/c80_queue.sv =====
// Short instruction queue between the front end and the execute stage.
// Depends on c80_pkg.
`default_nettype none
module c80_queue import c80_pkg::*; #(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire instr_t push_data,
    output logic        full,
    input  wire logic   pop,
    output instr_t      pop_data,
    output logic        empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    instr_t        mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else begin
            if (push) begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== sv/c80_front.sv =====
// Front end: accepts instructions and turns unsupported ones into no-ops.
// Depends on c80_pkg and the channel interfaces.
`default_nettype none
module c80_front import c80_pkg::*; (
    c80_instr_if.sink in,
    input  wire logic full,
    output logic      push,
    output instr_t    push_data
);
    logic mem_ref;

    always_comb begin
        mem_ref = 1'b0;
        case (in.payload.operation)
            OP_MOV: mem_ref = (in.payload.dest_reg == REG_MEM) ||
                              (in.payload.src_reg == REG_MEM);
            OP_MVI, OP_INR, OP_DCR: mem_ref = (in.payload.dest_reg == REG_MEM);
            OP_ALU: mem_ref = !in.payload.use_immediate &&
                              (in.payload.src_reg == REG_MEM);
            default: mem_ref = 1'b0;
        endcase
        push_data = in.payload;
        if (mem_ref || in.payload.operation > OP_PCHL) begin
            push_data.operation = OP_NOP;
        end
    end

    assign in.ready = !full;
    assign push = in.valid && !full;
endmodule
`default_nettype wire

// ===== sv/c80_exec.sv =====
// Execute stage: register file, flags and combinational ALU with an output register.
// Depends on c80_pkg.
`default_nettype none
module c80_exec import c80_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   empty,
    input  wire instr_t ins,
    output logic        pop,
    c80_result_if.source out
);
    logic [7:0]  regs_reg [7];
    logic [7:0]  regs_next [7];
    logic [4:0]  fl_reg, fl_next;
    logic [15:0] sp_reg, sp_next;
    logic        vld_reg;
    result_t     res_reg;
    logic        taken;
    logic [15:0] npc;

    logic [7:0]  a, b, r8;
    logic [8:0]  s9;
    logic [4:0]  s5;
    logic        cy, ci;
    logic [15:0] pr, hl, de, p16;
    logic [16:0] s17;

    function automatic logic [4:0] szp(input logic [7:0] r, input logic ac, input logic c);
        szp = {r[7], r == 8'd0, ac, ~^r, c};
    endfunction

    assign pop = !empty && (!vld_reg || out.ready);

    always_comb begin
        regs_next = regs_reg;
        fl_next = fl_reg;
        sp_next = sp_reg;
        taken = 1'b0;
        npc = '0;
        a = regs_reg[REG_A];
        cy = fl_reg[0];
        hl = {regs_reg[4], regs_reg[5]};
        de = {regs_reg[2], regs_reg[3]};
        case (ins.pair_sel)
            2'd0: pr = {regs_reg[0], regs_reg[1]};
            2'd1: pr = de;
            2'd2: pr = hl;
            default: pr = sp_reg;
        endcase
        b = ins.use_immediate ? ins.immediate[7:0] :
            regs_reg[ins.src_reg[2:0] == REG_MEM ? 3'd0 : ins.src_reg];
        r8 = regs_reg[ins.dest_reg == REG_MEM ? 3'd0 : ins.dest_reg];
        ci = 1'b0;
        s9 = '0;
        s5 = '0;
        p16 = '0;
        s17 = '0;
        case (ins.operation)
            OP_MOV: regs_next[ins.dest_reg] = regs_reg[ins.src_reg];
            OP_MVI: regs_next[ins.dest_reg] = ins.immediate[7:0];
            OP_LXI, OP_INX, OP_DCX: begin
                if (ins.operation == OP_LXI) p16 = ins.immediate;
                else if (ins.operation == OP_INX) p16 = pr + 16'd1;
                else p16 = pr - 16'd1;
                case (ins.pair_sel)
                    2'd0: {regs_next[0], regs_next[1]} = p16;
                    2'd1: {regs_next[2], regs_next[3]} = p16;
                    2'd2: {regs_next[4], regs_next[5]} = p16;
                    default: sp_next = p16;
                endcase
            end
            OP_ALU: begin
                case (ins.variant)
                    ALU_ADD, ALU_ADC: begin
                        ci = (ins.variant == ALU_ADC) && cy;
                        s9 = {1'b0, a} + {1'b0, b} + 9'(ci);
                        s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(ci);
                        fl_next = szp(s9[7:0], s5[4], s9[8]);
                        regs_next[REG_A] = s9[7:0];
                    end
                    ALU_SUB, ALU_SBB, ALU_CMP: begin
                        ci = (ins.variant == ALU_SBB) && cy;
                        s9 = {1'b0, a} + {1'b0, ~b} + 9'(!ci);
                        s5 = {1'b0, a[3:0]} + {1'b0, ~b[3:0]} + 5'(!ci);
                        fl_next = szp(s9[7:0], s5[4], !s9[8]);
                        if (ins.variant != ALU_CMP) regs_next[REG_A] = s9[7:0];
                    end
                    ALU_ANA: begin
                        fl_next = szp(a & b, a[3] | b[3], 1'b0);
                        regs_next[REG_A] = a & b;
                    end
                    ALU_XRA: begin
                        fl_next = szp(a ^ b, 1'b0, 1'b0);
                        regs_next[REG_A] = a ^ b;
                    end
                    ALU_ORA: begin
                        fl_next = szp(a | b, 1'b0, 1'b0);
                        regs_next[REG_A] = a | b;
                    end
                    default: ;
                endcase
            end
            OP_INR: begin
                regs_next[ins.dest_reg] = r8 + 8'd1;
                fl_next = szp(r8 + 8'd1, r8[3:0] == 4'hf, cy);
            end
            OP_DCR: begin
                regs_next[ins.dest_reg] = r8 - 8'd1;
                fl_next = szp(r8 - 8'd1, r8[3:0] != 4'h0, cy);
            end
            OP_DAD: begin
                s17 = {1'b0, hl} + {1'b0, pr};
                {regs_next[4], regs_next[5]} = s17[15:0];
                fl_next[0] = s17[16];
            end
            OP_ROT: begin
                case (ins.variant)
                    ROT_RLC: begin regs_next[REG_A] = {a[6:0], a[7]}; fl_next[0] = a[7]; end
                    ROT_RRC: begin regs_next[REG_A] = {a[0], a[7:1]}; fl_next[0] = a[0]; end
                    ROT_RAL: begin regs_next[REG_A] = {a[6:0], cy}; fl_next[0] = a[7]; end
                    ROT_RAR: begin regs_next[REG_A] = {cy, a[7:1]}; fl_next[0] = a[0]; end
                    default: ;
                endcase
            end
            OP_CMA: regs_next[REG_A] = ~a;
            OP_STC: fl_next[0] = 1'b1;
            OP_CMC: fl_next[0] = ~cy;
            OP_XCHG: begin
                {regs_next[2], regs_next[3]} = hl;
                {regs_next[4], regs_next[5]} = de;
            end
            OP_SPHL: sp_next = hl;
            OP_JMP: begin
                case (ins.variant)
                    4'd0: taken = !fl_reg[3];
                    4'd1: taken = fl_reg[3];
                    4'd2: taken = !fl_reg[0];
                    4'd3: taken = fl_reg[0];
                    4'd4: taken = !fl_reg[1];
                    4'd5: taken = fl_reg[1];
                    4'd6: taken = !fl_reg[4];
                    4'd7: taken = fl_reg[4];
                    4'd8: taken = 1'b1;
                    default: taken = 1'b0;
                endcase
                npc = taken ? ins.immediate : 16'd0;
            end
            OP_PCHL: begin
                taken = 1'b1;
                npc = hl;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < 7; i++) regs_reg[i] <= '0;
            fl_reg <= '0;
            sp_reg <= '0;
            vld_reg <= 1'b0;
        end
        else begin
            if (pop) begin
                regs_reg <= regs_next;
                fl_reg <= fl_next;
                sp_reg <= sp_next;
                vld_reg <= 1'b1;
            end
            else if (out.ready) begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (pop) begin
            res_reg.acc <= regs_next[REG_A];
            res_reg.psw_flags <= {fl_next[4], fl_next[3], 1'b0, fl_next[2], 1'b0,
                                  fl_next[1], 1'b1, fl_next[0]};
            res_reg.jump_taken <= taken;
            res_reg.new_pc <= npc;
            res_reg.pair_bc <= {regs_next[0], regs_next[1]};
            res_reg.pair_de <= {regs_next[2], regs_next[3]};
            res_reg.pair_hl <= {regs_next[4], regs_next[5]};
            res_reg.stack_ptr <= sp_next;
        end
    end

    assign out.valid = vld_reg;
    assign out.payload = res_reg;
endmodule
`default_nettype wire
